>>> rtl/stm_pkg.sv
// Package for the scaler trigger timestamp matcher.
// Holds the item types, register codes, state encoding and saturation helper.
// Depends on nothing.
package stm_pkg;

	localparam int TABLE_DEPTH_DEF = 4096;
	localparam int TIME_BITS_DEF   = 48;
	localparam int QUEUE_DEPTH     = 4;

	localparam int CFG_W     = 41;
	localparam int CFG_IDX_W = 2;
	localparam int WINDOW_W  = 20;
	localparam int OFFSET_W  = 41;
	localparam int ORIGIN_W  = 32;
	localparam int INDEX_W   = 32;
	localparam int FIELD_T_W = 48;

	localparam int WIDE_W    = 66;
	localparam int DIST_W    = 65;
	localparam int DRIFT_DIV = 3000000;

	localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(1000);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MATCH_WINDOW  = 2'd0,
		CFG_ALIGN_OFFSET  = 2'd1,
		CFG_SCALER_ORIGIN = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_MATCH = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t                 cmd;
		logic [FIELD_T_W-1:0] trigger_time;
		logic [INDEX_W-1:0]   trigger_index;
		logic [31:0]          scaler_value;
	} in_item_t;

	typedef struct packed {
		logic [FIELD_T_W-1:0] vme_time;
		logic [FIELD_T_W-1:0] matched_time;
		logic [INDEX_W-1:0]   matched_index;
	} out_item_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD,
		S_VME,
		S_MUL_LO,
		S_MUL_HI,
		S_QEST,
		S_QCHK,
		S_CORR1,
		S_CORR2,
		S_BOUNDS,
		S_BS_RD,
		S_BS_CMP,
		S_SC_RD,
		S_SC_CMP,
		S_EMIT
	} back_state_t;

	localparam logic signed [WIDE_W-1:0] S64_MAX = 66'sd9223372036854775807;
	localparam logic signed [WIDE_W-1:0] S64_MIN = -66'sd9223372036854775808;

	function automatic logic signed [63:0] sat64(input logic signed [WIDE_W-1:0] x);
		logic signed [63:0] r;
		if (x > S64_MAX) begin
			r = 64'sh7FFF_FFFF_FFFF_FFFF;
		end else if (x < S64_MIN) begin
			r = 64'sh8000_0000_0000_0000;
		end else begin
			r = x[63:0];
		end
		return r;
	endfunction

endpackage

>>> rtl/stm_front.sv
// Front part of the matcher: accepts items, drops zero samples, unwraps scalers.
// Depends on stm_pkg; feeds stm_queue.
module stm_front import stm_pkg::*; #(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic                           full,
	input  in_item_t                       item,
	output logic                           q_push,
	output logic [1+TIME_BITS+INDEX_W-1:0] q_data
);

	localparam logic [TIME_BITS-1:0] WRAP_STEP = TIME_BITS'(64'd1 << 32);

	logic [TIME_BITS-1:0] wrap_q, prev_q;
	logic [TIME_BITS-1:0] sum0, sum1, scaler;
	logic                 is_zero, wrapped;

	assign is_zero = (item.cmd == CMD_MATCH) && (item.scaler_value == 32'd0);
	assign q_push  = push && !full && !is_zero;
	assign sum0    = TIME_BITS'(item.scaler_value) + wrap_q;
	assign sum1    = sum0 + WRAP_STEP;
	assign wrapped = sum0 < prev_q;
	assign scaler  = wrapped ? sum1 : sum0;

	always_comb begin
		if (item.cmd == CMD_MATCH) begin
			q_data = {item.cmd, scaler, item.trigger_index};
		end else begin
			q_data = {item.cmd, TIME_BITS'(item.trigger_time), item.trigger_index};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_q <= '0;
			prev_q <= '0;
		end else if (q_push && item.cmd == CMD_MATCH) begin
			prev_q <= scaler;
			if (wrapped) begin
				wrap_q <= wrap_q + WRAP_STEP;
			end
		end
	end

endmodule

>>> rtl/stm_queue.sv
// Short queue between the front and back parts of the matcher.
// Depends on stm_pkg only for the default depth; generic width and depth.
module stm_queue import stm_pkg::*; #(
	parameter int WIDTH = 1,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int PW = $clog2(DEPTH);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wp_q, rp_q;
	logic [PW:0]      cnt_q;

	assign full  = cnt_q == (PW+1)'(DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= (wp_q == PW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= (rp_q == PW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (PW+1)'(wr) - (PW+1)'(rd);
		end
	end

endmodule

>>> rtl/stm_back.sv
// Back part of the matcher: trigger table, drift term, binary search and scan.
// Depends on stm_pkg; reads items from stm_queue and holds the result register.
module stm_back import stm_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int TIME_BITS   = TIME_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_empty,
	input  logic [1+TIME_BITS+INDEX_W-1:0] q_data,
	output logic                           q_pop,
	input  logic [WINDOW_W-1:0]            window,
	input  logic signed [OFFSET_W-1:0]     offset,
	input  logic [ORIGIN_W-1:0]            origin,
	input  logic                           pop,
	output logic                           empty,
	output out_item_t                      result
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = AW + 1;
	localparam int QW = 1 + TIME_BITS + INDEX_W;
	localparam int DW = TIME_BITS + 1;
	localparam int RW = DW - 21;
	localparam int LW = (DW + 1) / 2;
	localparam int HW = DW - LW;

	// Reciprocal of the drift divisor scaled by 2^DW; the estimate it gives is at
	// most one below the true quotient, so a single correction step suffices.
	localparam logic [RW-1:0] RECIP =
		RW'({1'b1, {DW{1'b0}}} / (DW+1)'(DRIFT_DIV));

	back_state_t state_q, state_d;

	logic [TIME_BITS-1:0] rel_mem [TABLE_DEPTH];
	logic [INDEX_W-1:0]   num_mem [TABLE_DEPTH];
	logic [TIME_BITS-1:0] rd_rel_q;
	logic [INDEX_W-1:0]   rd_num_q;
	logic [AW-1:0]        rd_addr;

	logic [TIME_BITS-1:0]     time_q, first_q, best_rel_q, rel;
	logic [INDEX_W-1:0]       idx_q, best_num_q;
	logic [CW-1:0]            count_q, lo_q, hi_q, scan_q, mid;
	logic signed [WIDE_W-1:0] vme_q, vme_c, r_s, diff, drift;
	logic [DW-1:0]            div_q, qd_q, rem_c;
	logic [LW+RW-1:0]         prod_lo_q;
	logic [HW+RW-1:0]         prod_hi_q;
	logic [DW+RW:0]           prod_sum;
	logic [RW-1:0]            quot_est_q, quot_q;
	logic                     neg_q, found_q, gt_hi, lt_lo, can_emit, load_ok;
	logic signed [63:0]       corr_q, key_lo_q, key_hi_q;
	logic [DIST_W-1:0]        best_d_q, gap;
	logic                     out_valid_q;
	out_item_t                out_q;

	assign empty    = !out_valid_q;
	assign result   = out_q;
	assign can_emit = !out_valid_q || pop;
	assign load_ok  = count_q < CW'(TABLE_DEPTH);
	assign mid      = lo_q + ((hi_q - lo_q) >> 1);

	assign rel = (count_q == '0) ? '0 :
	             (time_q >= first_q) ? time_q - first_q : '0;

	assign vme_c    = $signed(WIDE_W'(time_q)) - $signed(WIDE_W'(origin));
	assign prod_sum = {1'b0, prod_hi_q, {LW{1'b0}}} + (DW+RW+1)'(prod_lo_q);
	assign rem_c    = div_q - qd_q;
	assign drift    = neg_q ? -$signed(WIDE_W'(quot_q)) : $signed(WIDE_W'(quot_q));

	assign r_s   = $signed(WIDE_W'(rd_rel_q));
	assign diff  = r_s - vme_q;
	assign gap   = (diff < 0) ? DIST_W'(-diff) : DIST_W'(diff);
	assign gt_hi = r_s > WIDE_W'(key_hi_q);
	assign lt_lo = r_s < WIDE_W'(key_lo_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (!q_empty) begin
					state_d = (cmd_t'(q_data[QW-1]) == CMD_MATCH) ? S_VME : S_LOAD;
				end
			end
			S_LOAD:   state_d = S_IDLE;
			S_VME:    state_d = S_MUL_LO;
			S_MUL_LO: state_d = S_MUL_HI;
			S_MUL_HI: state_d = S_QEST;
			S_QEST:   state_d = S_QCHK;
			S_QCHK:   state_d = S_CORR1;
			S_CORR1:  state_d = S_CORR2;
			S_CORR2:  state_d = S_BOUNDS;
			S_BOUNDS: state_d = S_BS_RD;
			S_BS_RD:  state_d = (lo_q < hi_q) ? S_BS_CMP : S_SC_RD;
			S_BS_CMP: state_d = S_BS_RD;
			S_SC_RD: begin
				if (scan_q < count_q) begin
					state_d = S_SC_CMP;
				end else begin
					state_d = found_q ? S_EMIT : S_IDLE;
				end
			end
			S_SC_CMP: begin
				if (gt_hi) begin
					state_d = found_q ? S_EMIT : S_IDLE;
				end else begin
					state_d = S_SC_RD;
				end
			end
			S_EMIT: begin
				if (can_emit) begin
					state_d = S_IDLE;
				end
			end
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		q_pop   = (state_q == S_IDLE) && !q_empty;
		rd_addr = scan_q[AW-1:0];
		case (state_q)
			S_BS_RD: rd_addr = mid[AW-1:0];
			default: rd_addr = scan_q[AW-1:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_LOAD && load_ok) begin
				count_q <= count_q + 1'b1;
			end
			if (state_q == S_EMIT && can_emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_LOAD && load_ok) begin
			rel_mem[count_q[AW-1:0]] <= rel;
			num_mem[count_q[AW-1:0]] <= idx_q;
		end
		rd_rel_q <= rel_mem[rd_addr];
		rd_num_q <= num_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				time_q <= q_data[QW-2 -: TIME_BITS];
				idx_q  <= q_data[INDEX_W-1:0];
			end
			S_LOAD: begin
				if (load_ok && count_q == '0) begin
					first_q <= time_q;
				end
			end
			S_VME: begin
				vme_q <= vme_c;
				neg_q <= vme_c < 0;
				div_q <= (vme_c < 0) ? DW'(-vme_c) : DW'(vme_c);
			end
			S_MUL_LO: prod_lo_q  <= div_q[LW-1:0] * RECIP;
			S_MUL_HI: prod_hi_q  <= div_q[DW-1:LW] * RECIP;
			S_QEST:   quot_est_q <= prod_sum[DW+RW-1:DW];
			S_QCHK:   qd_q       <= DW'(quot_est_q) * DW'(DRIFT_DIV);
			S_CORR1: begin
				corr_q <= sat64(vme_q + WIDE_W'(offset));
				quot_q <= (rem_c >= DW'(DRIFT_DIV)) ? quot_est_q + 1'b1 : quot_est_q;
			end
			S_CORR2: corr_q <= sat64(WIDE_W'(corr_q) - drift);
			S_BOUNDS: begin
				key_lo_q <= sat64(WIDE_W'(corr_q) - $signed(WIDE_W'(window)));
				key_hi_q <= sat64(WIDE_W'(corr_q) + $signed(WIDE_W'(window)));
				lo_q     <= '0;
				hi_q     <= count_q;
				best_d_q <= DIST_W'({window, 3'b000}) + DIST_W'({window, 1'b0});
				found_q  <= 1'b0;
			end
			S_BS_RD: begin
				scan_q <= lo_q;
			end
			S_BS_CMP: begin
				if (lt_lo) begin
					lo_q <= mid + 1'b1;
				end else begin
					hi_q <= mid;
				end
			end
			S_SC_CMP: begin
				if (!gt_hi) begin
					if (gap < best_d_q) begin
						best_d_q   <= gap;
						best_rel_q <= rd_rel_q;
						best_num_q <= rd_num_q;
						found_q    <= 1'b1;
					end
					scan_q <= scan_q + 1'b1;
				end
			end
			S_EMIT: begin
				if (can_emit) begin
					out_q.vme_time      <= FIELD_T_W'(time_q);
					out_q.matched_time  <= FIELD_T_W'(TIME_BITS'(best_rel_q + first_q));
					out_q.matched_index <= best_num_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> rtl/scaler_trigger_timestamp_matcher.sv
// Top level of the scaler trigger timestamp matcher.
// Depends on stm_pkg, stm_front, stm_queue and stm_back.
//
// A load item passes through the load state of the back part once it reaches the
// head of the four-entry queue. A sample item goes through the relative time, the
// drift term (a reciprocal multiplication in two halves with one correction
// step) and the offset and window arithmetic, then a binary search over the
// loaded triggers (a read and a compare state per step) with a closing read, a
// read and a compare state per trigger examined in the window, a final read when
// the scan runs to the end of the table, and a move of a match into the result
// register, where it waits while an earlier result is still unread. All table
// reads use the one port of the trigger memory. Zero samples are dropped at the
// input and never reach the queue. There is no clearing pass.
module scaler_trigger_timestamp_matcher import stm_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int TIME_BITS   = TIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  in_item_t             item,
	output logic                 empty,
	input  logic                 pop,
	output out_item_t            result,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int QW = 1 + TIME_BITS + INDEX_W;

	logic                        q_push, q_pop, q_empty;
	logic [QW-1:0]               q_wdata, q_rdata;
	logic [WINDOW_W-1:0]         window_q;
	logic signed [OFFSET_W-1:0]  offset_q;
	logic [ORIGIN_W-1:0]         origin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
			offset_q <= '0;
			origin_q <= '0;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				CFG_MATCH_WINDOW:  window_q <= cfg_data[WINDOW_W-1:0];
				CFG_ALIGN_OFFSET:  offset_q <= $signed(cfg_data[OFFSET_W-1:0]);
				CFG_SCALER_ORIGIN: origin_q <= cfg_data[ORIGIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	stm_front #(.TIME_BITS(TIME_BITS)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.q_push (q_push),
		.q_data (q_wdata)
	);

	stm_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_push),
		.wdata  (q_wdata),
		.rd     (q_pop),
		.rdata  (q_rdata),
		.full   (full),
		.empty  (q_empty)
	);

	stm_back #(.TABLE_DEPTH(TABLE_DEPTH), .TIME_BITS(TIME_BITS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (q_rdata),
		.q_pop   (q_pop),
		.window  (window_q),
		.offset  (offset_q),
		.origin  (origin_q),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

endmodule

>>> rtl/stm_checker.sv
// Port-level checks for the scaler trigger timestamp matcher.
// Depends on stm_pkg; bound to the top level at the end of this file.
module stm_checker import stm_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      push,
	input logic      full,
	input logic      empty,
	input logic      pop,
	input out_item_t result
);

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result changed or vanished");

	a_scaler_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.vme_time[31:0] != 32'd0))
		else $error("result shown for a zero scaler sample");

	a_full_needs_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("queue became full without an item pushed");

endmodule

bind scaler_trigger_timestamp_matcher stm_checker u_stm_checker (.*);
